// File: design/sm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and helper functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

    typedef logic [31:0] t_word;
    // Eight working words, index 0 is word A, index 7 is word H.
    typedef t_word [7:0] t_hash_words;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } t_state;

    localparam t_hash_words SM3_IV = {
        32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
        32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
    };

    localparam t_word SM3_T_LOW  = 32'h79CC4519;
    localparam t_word SM3_T_HIGH = 32'h7A879D8A;
    localparam logic [7:0] SM3_PAD_MARK = 8'h80;
    localparam logic [5:0] SM3_LAST_POS = 6'd63;
    localparam logic [5:0] SM3_LAST_RND = 6'd63;
    localparam logic [5:0] SM3_LOW_LAST_RND = 6'd15;
    localparam logic [2:0] SM3_LAST_IDX = 3'd7;

    function automatic t_word rotl32(input t_word x, input logic [4:0] n);
        return (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic t_word perm0(input t_word x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic t_word perm1(input t_word x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage : sm3_pkg
`default_nettype wire

// File: design/sm3_hash_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_hash_engine
// SM3 (GB/T 32905) hash over a byte stream, 256-bit digest out as eight words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | i_in_valid/o_in_stall | data_byte, byte_valid, last
//  out     | output    | o_out_valid/i_out_stall | digest_word, word_index, last_word
//
//  A plain byte is taken without stalling the input. A byte that fills the 64-byte block holds the
//  input stalled for 64 rounds of the shared round unit and one fold.
//  An item with last set starts padding, one byte per cycle through the block register,
//  with one or two compressions, then eight output words.
//  Reset (synchronous, active low) loads the initial value and clears counts.
//  Output stall holds the current digest word; the input stays stalled.
// ----------------------------------------------------------------------------
module sm3_hash_engine
    import sm3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_state       r_state, n_state;
    logic [5:0]   r_rnd, n_rnd;
    logic [5:0]   r_pos, n_pos;
    logic [60:0]  r_count, n_count;
    logic [511:0] r_blk, n_blk;
    t_hash_words  r_cv, n_cv;
    t_hash_words  r_v, n_v;
    t_word        r_t, n_t;
    logic         r_pad, n_pad;
    logic         r_mark, n_mark;
    logic         r_wrap, n_wrap;
    logic         r_final, n_final;
    logic [2:0]   r_oidx, n_oidx;

    t_hash_words  w_v_round;
    t_word        w_w_new;
    logic [63:0]  w_len_bits;
    logic [7:0]   w_len_byte;
    logic [7:0]   w_pad_byte;
    logic         w_tail;
    logic         w_is_len;

    // Shared round unit
    sm3_round u_round (
        .i_v     (r_v),
        .i_blk   (r_blk),
        .i_t     (r_t),
        .i_early (r_rnd[5:4] == 2'b00),
        .o_v     (w_v_round),
        .o_w_new (w_w_new)
    );

    // Padding byte selection
    assign w_len_bits = {r_count, 3'b000};
    assign w_len_byte = 8'(w_len_bits >> {3'd7 - r_pos[2:0], 3'b000});
    assign w_tail     = (r_pos[5:3] == 3'b111);
    assign w_is_len   = !r_mark && w_tail && !r_wrap;
    assign w_pad_byte = r_mark ? SM3_PAD_MARK : (w_is_len ? w_len_byte : 8'h00);

    // Outputs straight from registers
    assign o_in_stall             = (r_state != ST_IDLE);
    assign o_out_valid            = (r_state == ST_OUT);
    assign o_out_data.digest_word = r_cv[r_oidx];
    assign o_out_data.word_index  = r_oidx;
    assign o_out_data.last_word   = (r_oidx == SM3_LAST_IDX);

    // State register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
            r_pos   <= '0;
            r_count <= '0;
            r_cv    <= SM3_IV;
            r_v     <= SM3_IV;
            r_t     <= SM3_T_LOW;
            r_pad   <= 1'b0;
            r_mark  <= 1'b0;
            r_wrap  <= 1'b0;
            r_final <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_cv    <= n_cv;
            r_v     <= n_v;
            r_t     <= n_t;
            r_pad   <= n_pad;
            r_mark  <= n_mark;
            r_wrap  <= n_wrap;
            r_final <= n_final;
            r_oidx  <= n_oidx;
        end
    end

    // Block window: payload only, no reset
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_pos   = r_pos;
        n_count = r_count;
        n_blk   = r_blk;
        n_cv    = r_cv;
        n_v     = r_v;
        n_t     = r_t;
        n_pad   = r_pad;
        n_mark  = r_mark;
        n_wrap  = r_wrap;
        n_final = r_final;
        n_oidx  = r_oidx;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    // Absorb the byte, then arm padding on last
                    if (i_in_data.byte_valid) begin
                        n_blk   = {r_blk[503:0], i_in_data.data_byte};
                        n_pos   = r_pos + 6'd1;
                        n_count = r_count + 61'd1;
                    end
                    if (i_in_data.last) begin
                        n_pad  = 1'b1;
                        n_mark = 1'b1;
                        n_wrap = 1'b0;
                    end
                    if (i_in_data.byte_valid && r_pos == SM3_LAST_POS) begin
                        n_state = ST_ROUND;
                        n_rnd   = '0;
                        n_t     = SM3_T_LOW;
                    end else if (i_in_data.last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                // Advance one round and slide the message window
                n_v   = w_v_round;
                n_blk = {r_blk[479:0], w_w_new};
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == SM3_LOW_LAST_RND) begin
                    n_t = rotl32(SM3_T_HIGH, 5'd16);
                end else begin
                    n_t = rotl32(r_t, 5'd1);
                end
                if (r_rnd == SM3_LAST_RND) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                // Fold the working words into the chaining value
                n_cv   = r_cv ^ r_v;
                n_v    = r_cv ^ r_v;
                n_oidx = '0;
                if (r_final) begin
                    n_state = ST_OUT;
                end else if (r_pad) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD: begin
                // Shift one padding byte: mark, zeros, then the bit length
                n_blk  = {r_blk[503:0], w_pad_byte};
                n_pos  = r_pos + 6'd1;
                n_mark = 1'b0;
                if (r_mark && w_tail) begin
                    n_wrap = 1'b1;
                end
                if (r_pos == SM3_LAST_POS) begin
                    n_state = ST_ROUND;
                    n_rnd   = '0;
                    n_t     = SM3_T_LOW;
                    n_wrap  = 1'b0;
                    if (w_is_len) begin
                        n_final = 1'b1;
                        n_pad   = 1'b0;
                    end
                end
            end
            ST_OUT: begin
                // Hand out digest words; restart the message after the last
                if (!i_out_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == SM3_LAST_IDX) begin
                        n_state = ST_IDLE;
                        n_cv    = SM3_IV;
                        n_v     = SM3_IV;
                        n_count = '0;
                        n_final = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Digest words go out only with the input held off
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("output valid while input open");

    // The fold always follows the final round
    a_fold_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd == SM3_LAST_RND) |=> (r_state == ST_FOLD))
        else $error("fold did not follow round 63");

    // The digest appears only on a block boundary
    a_out_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos == 6'd0 && !r_pad))
        else $error("digest out of block alignment");

    // The last word restarts the engine for a fresh message
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_data.last_word)
        |=> (r_state == ST_IDLE && r_count == '0 && r_cv == SM3_IV))
        else $error("engine did not restart after digest");

endmodule : sm3_hash_engine
`default_nettype wire

// File: design/sm3_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm3_round
// One SM3 compression round plus one step of message expansion, shared by
// all 64 rounds of every block.
// ----------------------------------------------------------------------------
module sm3_round
    import sm3_pkg::*;
(
    input  t_hash_words  i_v,
    input  logic [511:0] i_blk,
    input  t_word        i_t,
    input  logic         i_early,
    output t_hash_words  o_v,
    output t_word        o_w_new
);

    t_word w_w [16];
    t_word w_a12, w_ss1, w_ss2, w_ff, w_gg, w_tt1, w_tt2;

    // Unpack the 16-word window, first word at the top
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_w[k] = i_blk[511 - 32 * k -: 32];
        end
    end

    // Expand the next message word from the window
    assign o_w_new = perm1(w_w[0] ^ w_w[7] ^ rotl32(w_w[13], 5'd15))
                   ^ rotl32(w_w[3], 5'd7) ^ w_w[10];

    // Round function
    always_comb begin
        w_a12 = rotl32(i_v[0], 5'd12);
        w_ss1 = rotl32(w_a12 + i_v[4] + i_t, 5'd7);
        w_ss2 = w_ss1 ^ w_a12;
        if (i_early) begin
            w_ff = i_v[0] ^ i_v[1] ^ i_v[2];
            w_gg = i_v[4] ^ i_v[5] ^ i_v[6];
        end else begin
            w_ff = (i_v[0] & i_v[1]) | (i_v[0] & i_v[2]) | (i_v[1] & i_v[2]);
            w_gg = (i_v[4] & i_v[5]) | (~i_v[4] & i_v[6]);
        end
        w_tt1 = w_ff + i_v[3] + w_ss2 + (w_w[0] ^ w_w[4]);
        w_tt2 = w_gg + i_v[7] + w_ss1 + w_w[0];
        o_v[0] = w_tt1;
        o_v[1] = i_v[0];
        o_v[2] = rotl32(i_v[1], 5'd9);
        o_v[3] = i_v[2];
        o_v[4] = perm0(w_tt2);
        o_v[5] = i_v[4];
        o_v[6] = rotl32(i_v[5], 5'd19);
        o_v[7] = i_v[6];
    end

endmodule : sm3_round
`default_nettype wire
